// ===== rtl/per_source_flood_isolator_macros.svh =====
// assertion macros for the per-source flood isolator
// used by the top level only, expects signals named clk and rst_n in scope
`ifndef PER_SOURCE_FLOOD_ISOLATOR_MACROS_SVH
`define PER_SOURCE_FLOOD_ISOLATOR_MACROS_SVH

// same-cycle implication, checked outside reset
`define FSI_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define FSI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/fsi_pkg.sv =====
// shared types and constants for the per-source flood isolator
// used by fsi_ctrl, fsi_dp and per_source_flood_isolator
package fsi_pkg;

    localparam int NODE_W   = 8;
    localparam int TIME_W   = 32;
    localparam int THRESH_W = 16;
    localparam int TOTAL_W  = 32;
    localparam int GAP_W    = 48;

    localparam logic [THRESH_W-1:0] THRESH_RESET = 16'd50;

    // item opcodes
    localparam logic OP_ARRIVAL = 1'b0;
    localparam logic OP_TICK    = 1'b1;

    // controller to datapath commands
    typedef struct packed {
        logic load_in;     // latch the accepted beat
        logic arr_rd;      // read the arriving node's counter
        logic idx_clear;   // restart the sweep index
        logic clr_step;    // zero one counter during the reset pass
        logic scan_rd;     // read one counter during the window scan
        logic arr_commit;  // write back an arrival and load the result
        logic tick_commit; // load the result of a window tick
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic idx_last;    // sweep index at last entry
        logic idx_full;    // sweep index past last entry
        logic chk_busy;    // a scanned counter is still being checked
        logic out_free;    // result register can take a new beat
    } stat_t;

endpackage

// ===== rtl/fsi_ctrl.sv =====
// sequencing state machine for the per-source flood isolator
// depends on fsi_pkg for the command and status structs
module fsi_ctrl
    import fsi_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    input  logic  op,
    input  stat_t stat,
    output logic  in_ready,
    output cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ARRIVE,
        ST_SCAN,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.idx_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    if (op == OP_TICK)
                    begin
                        cmd.idx_clear = 1'b1;
                        state_next    = ST_SCAN;
                    end
                    else
                    begin
                        cmd.arr_rd = 1'b1;
                        state_next = ST_ARRIVE;
                    end
                end
            end
            ST_ARRIVE:
            begin
                if (stat.out_free)
                begin
                    cmd.arr_commit = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_rd = !stat.idx_full;
                if (stat.idx_full && !stat.chk_busy)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.tick_commit = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

// ===== rtl/fsi_dp.sv =====
// datapath for the per-source flood isolator: counter memory, totals, result register
// depends on fsi_pkg, driven by fsi_ctrl commands
module fsi_dp
    import fsi_pkg::*;
#(
    parameter int NODE_COUNT = 256,
    parameter int COUNT_BITS = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  cmd_t                cmd,
    output stat_t               stat,
    input  logic [NODE_W-1:0]   node_id,
    input  logic [TIME_W-1:0]   arrival_time,
    input  logic                cfg_we,
    input  logic [THRESH_W-1:0] cfg_data,
    input  logic                out_ready,
    output logic                out_valid,
    output logic                accepted,
    output logic                attacker_valid,
    output logic [NODE_W-1:0]   attacker_node,
    output logic [TOTAL_W-1:0]  packets_seen,
    output logic [TOTAL_W-1:0]  packets_dropped,
    output logic [GAP_W-1:0]    gap_total,
    output logic [TOTAL_W-1:0]  gap_samples_seen
);

    localparam int IDX_W = $clog2(NODE_COUNT);
    localparam int EXT_W = (IDX_W + 1 > NODE_W) ? IDX_W + 1 : NODE_W;
    localparam int CMP_W = (COUNT_BITS > THRESH_W) ? COUNT_BITS : THRESH_W;
    localparam logic [IDX_W:0] IDX_END  = (IDX_W + 1)'(NODE_COUNT);
    localparam logic [IDX_W:0] IDX_LAST = (IDX_W + 1)'(NODE_COUNT - 1);
    localparam logic [EXT_W-1:0] NODE_LIMIT = EXT_W'(NODE_COUNT);

    // counter store
    logic [COUNT_BITS-1:0] counts_mem [NODE_COUNT];
    logic [COUNT_BITS-1:0] rd_data_reg;
    logic [IDX_W-1:0]      rd_addr;
    logic                  rd_en;
    logic [IDX_W-1:0]      wr_addr;
    logic [COUNT_BITS-1:0] wr_data;
    logic                  wr_en;

    // sweep control
    logic [IDX_W:0]   idx_reg;
    logic             chk_valid_reg;
    logic [IDX_W-1:0] chk_idx_reg;

    // latched beat
    logic [NODE_W-1:0] node_reg;
    logic [TIME_W-1:0] time_reg;

    // block state
    logic [THRESH_W-1:0] thr_reg;
    logic [TOTAL_W-1:0]  total_reg;
    logic [TOTAL_W-1:0]  dropped_reg;
    logic                iso_flag_reg;
    logic [NODE_W-1:0]   iso_node_reg;
    logic [TIME_W-1:0]   prev_reg;
    logic [GAP_W-1:0]    gap_acc_reg;
    logic [TOTAL_W-1:0]  gap_cnt_reg;

    // result register
    logic                out_valid_reg;
    logic                acc_out_reg;
    logic                att_valid_out_reg;
    logic [NODE_W-1:0]   att_node_out_reg;
    logic [TOTAL_W-1:0]  seen_out_reg;
    logic [TOTAL_W-1:0]  dropped_out_reg;
    logic [GAP_W-1:0]    gap_out_reg;
    logic [TOTAL_W-1:0]  samples_out_reg;

    // arrival arithmetic
    logic [EXT_W-1:0]      in_node_ext;
    logic [EXT_W-1:0]      node_ext;
    logic                  in_range;
    logic [COUNT_BITS-1:0] cnt_inc;
    logic [TIME_W-1:0]     gap_diff;
    logic [GAP_W:0]        gap_sum;
    logic                  gap_on;
    logic [GAP_W-1:0]      gap_next;
    logic [TOTAL_W-1:0]    gap_cnt_next;
    logic [TOTAL_W-1:0]    total_next;
    logic                  drop;
    logic [TOTAL_W-1:0]    dropped_next;
    logic                  iso_hit;

    assign in_node_ext = EXT_W'(node_id);
    assign node_ext    = EXT_W'(node_reg);
    assign in_range    = (node_ext < NODE_LIMIT);

    assign cnt_inc      = (rd_data_reg == '1) ? rd_data_reg : rd_data_reg + COUNT_BITS'(1);
    assign gap_diff     = time_reg - prev_reg;
    assign gap_sum      = {1'b0, gap_acc_reg} + (GAP_W + 1)'(gap_diff);
    assign gap_on       = (prev_reg != '0);
    assign gap_next     = !gap_on ? gap_acc_reg :
                          (gap_sum[GAP_W] ? '1 : gap_sum[GAP_W-1:0]);
    assign gap_cnt_next = gap_on ? gap_cnt_reg + TOTAL_W'(1) : gap_cnt_reg;
    assign total_next   = total_reg + TOTAL_W'(1);
    assign drop         = iso_flag_reg && (node_reg == iso_node_reg);
    assign dropped_next = drop ? dropped_reg + TOTAL_W'(1) : dropped_reg;

    assign iso_hit = chk_valid_reg && !iso_flag_reg &&
                     (CMP_W'(rd_data_reg) > CMP_W'(thr_reg));

    // read port: arriving node at accept, sweep index during scan
    assign rd_en = cmd.arr_rd || cmd.scan_rd;

    always_comb
    begin
        if (cmd.arr_rd)
        begin
            rd_addr = (in_node_ext < NODE_LIMIT) ? in_node_ext[IDX_W-1:0] : '0;
        end
        else
        begin
            rd_addr = idx_reg[IDX_W-1:0];
        end
    end

    // write port: clear pass, scan clear, or arrival write-back
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = idx_reg[IDX_W-1:0];
        wr_data = '0;
        if (cmd.clr_step)
        begin
            wr_en = 1'b1;
        end
        else if (chk_valid_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = chk_idx_reg;
        end
        else if (cmd.arr_commit && in_range)
        begin
            wr_en   = 1'b1;
            wr_addr = node_ext[IDX_W-1:0];
            wr_data = cnt_inc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            counts_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= counts_mem[rd_addr];
        end
    end

    // sweep index and scan pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            chk_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.idx_clear)
            begin
                idx_reg <= '0;
            end
            else if (cmd.clr_step || cmd.scan_rd)
            begin
                idx_reg <= idx_reg + (IDX_W + 1)'(1);
            end
            chk_valid_reg <= cmd.scan_rd;
        end
    end

    always_ff @(posedge clk)
    begin
        chk_idx_reg <= idx_reg[IDX_W-1:0];
        if (cmd.load_in)
        begin
            node_reg <= node_id;
            time_reg <= arrival_time;
        end
    end

    // block state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg      <= THRESH_RESET;
            total_reg    <= '0;
            dropped_reg  <= '0;
            iso_flag_reg <= 1'b0;
            iso_node_reg <= '0;
            prev_reg     <= '0;
            gap_acc_reg  <= '0;
            gap_cnt_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                thr_reg <= cfg_data;
            end
            if (iso_hit)
            begin
                iso_flag_reg <= 1'b1;
                iso_node_reg <= NODE_W'(chk_idx_reg);
            end
            if (cmd.arr_commit)
            begin
                total_reg   <= total_next;
                dropped_reg <= dropped_next;
                prev_reg    <= time_reg;
                gap_acc_reg <= gap_next;
                gap_cnt_reg <= gap_cnt_next;
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg     <= 1'b0;
            acc_out_reg       <= 1'b0;
            att_valid_out_reg <= 1'b0;
            att_node_out_reg  <= '0;
            seen_out_reg      <= '0;
            dropped_out_reg   <= '0;
            gap_out_reg       <= '0;
            samples_out_reg   <= '0;
        end
        else
        begin
            if (cmd.arr_commit)
            begin
                out_valid_reg     <= 1'b1;
                acc_out_reg       <= !drop;
                att_valid_out_reg <= iso_flag_reg;
                att_node_out_reg  <= iso_node_reg;
                seen_out_reg      <= total_next;
                dropped_out_reg   <= dropped_next;
                gap_out_reg       <= gap_next;
                samples_out_reg   <= gap_cnt_next;
            end
            else if (cmd.tick_commit)
            begin
                out_valid_reg     <= 1'b1;
                acc_out_reg       <= 1'b0;
                att_valid_out_reg <= iso_flag_reg;
                att_node_out_reg  <= iso_node_reg;
                seen_out_reg      <= total_reg;
                dropped_out_reg   <= dropped_reg;
                gap_out_reg       <= gap_acc_reg;
                samples_out_reg   <= gap_cnt_reg;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.idx_last = (idx_reg == IDX_LAST);
    assign stat.idx_full = (idx_reg == IDX_END);
    assign stat.chk_busy = chk_valid_reg;
    assign stat.out_free = !out_valid_reg || out_ready;

    assign out_valid        = out_valid_reg;
    assign accepted         = acc_out_reg;
    assign attacker_valid   = att_valid_out_reg;
    assign attacker_node    = att_node_out_reg;
    assign packets_seen     = seen_out_reg;
    assign packets_dropped  = dropped_out_reg;
    assign gap_total        = gap_out_reg;
    assign gap_samples_seen = samples_out_reg;

endmodule

// ===== rtl/per_source_flood_isolator.sv =====
// per-source packet flood isolator, top level
// depends on fsi_pkg, fsi_ctrl, fsi_dp and per_source_flood_isolator_macros.svh

// Counts packet arrivals per source node in a window, tracks totals and the
// sum of inter-arrival gaps, and on a window tick isolates the lowest node whose
// count exceeded the window threshold, if no node is isolated yet; arrivals
// from that node are then dropped. Each accepted beat yields exactly one result
// beat. An arrival reads the node's counter from the counter memory at accept,
// then writes it back and loads the result once the result register is free. A
// window tick scans the counters: the scan reads one counter per cycle through
// the same memory read port and checks and zeroes it in the cycle after, then
// the last check drains, the result is loaded once the result register is free
// and the input reopens. Out of reset the block first zeroes the counter memory
// in a pass over every entry, with in_ready low; configuration writes are taken
// at any time. The result register lets a finished result wait on out_ready
// while the next beat is being worked on; work stalls only at the point of
// loading a new result.

`include "per_source_flood_isolator_macros.svh"

module per_source_flood_isolator
    import fsi_pkg::*;
#(
    parameter int NODE_COUNT = 256,
    parameter int COUNT_BITS = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    // item channel
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                op,
    input  logic [NODE_W-1:0]   node_id,
    input  logic [TIME_W-1:0]   arrival_time,
    // threshold write channel
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [THRESH_W-1:0] cfg_data,
    // result channel
    output logic                out_valid,
    input  logic                out_ready,
    output logic                accepted,
    output logic                attacker_valid,
    output logic [NODE_W-1:0]   attacker_node,
    output logic [TOTAL_W-1:0]  packets_seen,
    output logic [TOTAL_W-1:0]  packets_dropped,
    output logic [GAP_W-1:0]    gap_total,
    output logic [TOTAL_W-1:0]  gap_samples_seen
);

    cmd_t  cmd;
    stat_t stat;

    // threshold register never blocks
    assign cfg_ready = 1'b1;

    // sequencer: reset clear pass, arrival read-modify-write, window scan
    fsi_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .op       (op),
        .stat     (stat),
        .in_ready (in_ready),
        .cmd      (cmd)
    );

    // counter memory, running totals and the result register
    fsi_dp #(
        .NODE_COUNT (NODE_COUNT),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .stat             (stat),
        .node_id          (node_id),
        .arrival_time     (arrival_time),
        .cfg_we           (cfg_valid),
        .cfg_data         (cfg_data),
        .out_ready        (out_ready),
        .out_valid        (out_valid),
        .accepted         (accepted),
        .attacker_valid   (attacker_valid),
        .attacker_node    (attacker_node),
        .packets_seen     (packets_seen),
        .packets_dropped  (packets_dropped),
        .gap_total        (gap_total),
        .gap_samples_seen (gap_samples_seen)
    );

    // one item in flight: an accepted beat keeps the input closed next cycle
    `FSI_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready,
        "input reopened after accept")

    // a committed result is always presented the following cycle
    `FSI_ASSERT_NEXT(a_commit_shows, cmd.arr_commit || cmd.tick_commit, out_valid,
        "committed result not presented")

    // isolation is permanent
    `FSI_ASSERT_NEXT(a_iso_sticky, attacker_valid, attacker_valid, "isolated node released")

    // datapath commands never overlap
    `FSI_ASSERT_NOW(a_mem_excl, 1'b1,
        $onehot0({cmd.clr_step, cmd.scan_rd, cmd.arr_rd, cmd.arr_commit, cmd.tick_commit}),
        "conflicting datapath commands")

endmodule
